>>> sv/tpc_pkg.sv
// ---------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the triangle plane clipper
// Corner and job records, register indexes, clip cases and back-end states.
// ---------------------------------------------------------------------------
package tpc_pkg;

    localparam int DIST_W = 51;
    localparam int RFRAC  = 30;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        vec_t  [2:0] v;
        dist_t [2:0] d;
        logic  [2:0] rm;
    } job_t;

    localparam logic [2:0] CFG_PX = 3'd0;
    localparam logic [2:0] CFG_PY = 3'd1;
    localparam logic [2:0] CFG_PZ = 3'd2;
    localparam logic [2:0] CFG_NX = 3'd3;
    localparam logic [2:0] CFG_NY = 3'd4;
    localparam logic [2:0] CFG_NZ = 3'd5;

    localparam logic [1:0] CC_KEEP = 2'd0;
    localparam logic [1:0] CC_ONE  = 2'd1;
    localparam logic [1:0] CC_TWO  = 2'd2;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SETUP,
        BS_DIV,
        BS_MUL,
        BS_FIN,
        BS_EMIT
    } back_state_t;

    function automatic logic [1:0] succ(input logic [1:0] i);
        succ = (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

endpackage

>>> sv/tpc_front.sv
// ---------------------------------------------------------------------------
// tpc_front: plane registers, distance pipeline and corner classification
// Two stages: products of normal and offset, then sum and sign test.
// ---------------------------------------------------------------------------
module tpc_front
    import tpc_pkg::*;
#(
    parameter int QDEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          push,
    output logic                          full,
    input  vec_t [2:0]                    in_tri,
    input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
    output logic                          wr_en,
    output job_t                          wr_job
);

    localparam int CW = $clog2(QDEPTH + 1);

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    logic               s1_v_reg, s2_v_reg;
    vec_t [2:0]         tri1_reg, tri2_reg;
    logic signed [48:0] prod_reg  [3][3];
    logic signed [48:0] prod_next [3][3];
    logic [CW:0]        used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= 16'sd32767;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PX:  px_reg <= cfg_data;
                CFG_PY:  py_reg <= cfg_data;
                CFG_PZ:  pz_reg <= cfg_data;
                CFG_NX:  nx_reg <= cfg_data[15:0];
                CFG_NY:  ny_reg <= cfg_data[15:0];
                CFG_NZ:  nz_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // reserve queue space for everything in flight
    assign used = {1'b0, q_count} + (CW+1)'(s1_v_reg) + (CW+1)'(s2_v_reg);
    assign full = (used >= (CW+1)'(QDEPTH));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i][0] = nx_reg * ($signed({tri1_reg[i].x[31], tri1_reg[i].x})
                                        - $signed({px_reg[31], px_reg}));
            prod_next[i][1] = ny_reg * ($signed({tri1_reg[i].y[31], tri1_reg[i].y})
                                        - $signed({py_reg[31], py_reg}));
            prod_next[i][2] = nz_reg * ($signed({tri1_reg[i].z[31], tri1_reg[i].z})
                                        - $signed({pz_reg[31], pz_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= push && !full;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            tri1_reg <= in_tri;
        tri2_reg <= tri1_reg;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        wr_job.v = tri2_reg;
        for (int i = 0; i < 3; i++)
        begin
            wr_job.d[i] = DIST_W'(prod_reg[i][0]) + DIST_W'(prod_reg[i][1])
                        + DIST_W'(prod_reg[i][2]);
            wr_job.rm[i] = !wr_job.d[i][DIST_W-1];
        end
    end

    assign wr_en = s2_v_reg;

endmodule

>>> sv/tpc_queue.sv
// ---------------------------------------------------------------------------
// tpc_queue: short job queue between classifier and clipping engine
// First-word-fall-through, read at the head pointer.
// ---------------------------------------------------------------------------
module tpc_queue
    import tpc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  job_t                         wr_data,
    input  logic                         rd_en,
    output job_t                         rd_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= bump(wp_reg);
            if (rd_en)
                rp_reg <= bump(rp_reg);
            cnt_reg <= cnt_reg + CW'(wr_en) - CW'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    assign rd_data = mem[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;

endmodule

>>> sv/tpc_back.sv
// ---------------------------------------------------------------------------
// tpc_back: clipping engine
// Edge ratio by restoring division, three cut products, result register.
// ---------------------------------------------------------------------------
module tpc_back
    import tpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        q_data,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output vec_t [2:0]  out_tri,
    output logic [1:0]  out_case,
    output logic        out_last
);

    back_state_t  st_reg, st_next;
    job_t         job_reg, job_next;
    logic [1:0]   k_reg, k_next;
    logic [1:0]   nrm_reg, nrm_next;
    logic         sel_reg, sel_next;
    logic         ridx_reg, ridx_next;
    logic [51:0]  rem_reg, rem_next;
    logic [51:0]  den_reg, den_next;
    logic [30:0]  r_reg, r_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [63:0]  prod_reg [3];
    logic [63:0]  prod_next [3];
    logic [2:0]   neg_reg, neg_next;
    vec_t [1:0]   e_reg, e_next;
    logic         ov_reg, ov_next;
    vec_t [2:0]   ot_reg, ot_next;
    logic [1:0]   oc_reg, oc_next;
    logic         ol_reg, ol_next;

    logic [1:0]   k1, k2, cnt_rm, qk;
    vec_t         p1, p2, cutv;
    dist_t        d1, d2;
    logic signed [51:0] dd;
    logic [51:0]  num, den;
    logic [52:0]  rem2;
    logic signed [32:0] diff [3];
    logic [32:0]  dmag [3];
    logic [63:0]  rsum [3];
    logic signed [35:0] cv [3];
    logic signed [31:0] cs [3];
    logic         slot_free;
    vec_t [2:0]   t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    assign k1 = succ(k_reg);
    assign k2 = succ(k1);

    // operands of the current edge cut
    always_comb
    begin
        if (nrm_reg == 2'd1)
        begin
            p1 = sel_reg ? job_reg.v[k_reg] : job_reg.v[k2];
            p2 = sel_reg ? job_reg.v[k1]    : job_reg.v[k_reg];
            d1 = sel_reg ? job_reg.d[k_reg] : job_reg.d[k2];
            d2 = sel_reg ? job_reg.d[k1]    : job_reg.d[k_reg];
        end
        else
        begin
            p1 = job_reg.v[k_reg];
            p2 = sel_reg ? job_reg.v[k2] : job_reg.v[k1];
            d1 = job_reg.d[k_reg];
            d2 = sel_reg ? job_reg.d[k2] : job_reg.d[k1];
        end
        dd   = 52'(d2) - 52'(d1);
        num  = d2[DIST_W-1] ? 52'(-52'(d2)) : 52'(d2);
        den  = dd[51] ? 52'(-dd) : 52'(dd);
        rem2 = {rem_reg, 1'b0};

        diff[0] = $signed({p1.x[31], p1.x}) - $signed({p2.x[31], p2.x});
        diff[1] = $signed({p1.y[31], p1.y}) - $signed({p2.y[31], p2.y});
        diff[2] = $signed({p1.z[31], p1.z}) - $signed({p2.z[31], p2.z});
        for (int i = 0; i < 3; i++)
        begin
            dmag[i]      = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
            prod_next[i] = 64'(dmag[i]) * 64'(r_reg);
            neg_next[i]  = diff[i][32];
            rsum[i]      = prod_reg[i] + (64'd1 << (RFRAC - 1));
        end
        cv[0] = 36'(p2.x);
        cv[1] = 36'(p2.y);
        cv[2] = 36'(p2.z);
        for (int i = 0; i < 3; i++)
        begin
            if (neg_reg[i])
                cv[i] = cv[i] - $signed({2'b00, rsum[i][63:RFRAC]});
            else
                cv[i] = cv[i] + $signed({2'b00, rsum[i][63:RFRAC]});
            cs[i] = sat32(cv[i]);
        end
        cutv.x = cs[0];
        cutv.y = cs[1];
        cutv.z = cs[2];
    end

    // corner count and key corner of a fresh job
    always_comb
    begin
        cnt_rm = 2'(q_data.rm[0]) + 2'(q_data.rm[1]) + 2'(q_data.rm[2]);
        if (cnt_rm == 2'd1)
            qk = q_data.rm[0] ? 2'd0 : (q_data.rm[1] ? 2'd1 : 2'd2);
        else
            qk = !q_data.rm[0] ? 2'd0 : (!q_data.rm[1] ? 2'd1 : 2'd2);
    end

    // triangle for two removed corners
    always_comb
    begin
        t        = job_reg.v;
        t[k1]    = e_reg[0];
        t[k2]    = e_reg[1];
    end

    assign slot_free = !ov_reg || pop;

    always_comb
    begin
        st_next   = st_reg;
        job_next  = job_reg;
        k_next    = k_reg;
        nrm_next  = nrm_reg;
        sel_next  = sel_reg;
        ridx_next = ridx_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        e_next    = e_reg;
        ov_next   = ov_reg && !pop;
        ot_next   = ot_reg;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        q_rd      = 1'b0;

        unique case (st_reg)
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd      = 1'b1;
                    job_next  = q_data;
                    k_next    = qk;
                    sel_next  = 1'b0;
                    ridx_next = 1'b0;
                    nrm_next  = cnt_rm;
                    // all three on the removed side: nothing comes out
                    if (q_data.rm == 3'b111)
                        st_next = BS_IDLE;
                    else if (cnt_rm == 2'd0)
                        st_next = BS_EMIT;
                    else
                        st_next = BS_SETUP;
                end
            end
            BS_SETUP:
            begin
                den_next = den;
                rem_next = num;
                cnt_next = '0;
                if (den == '0)
                begin
                    r_next  = '0;
                    st_next = BS_MUL;
                end
                else if (num >= den)
                begin
                    r_next  = 31'(1) << RFRAC;
                    st_next = BS_MUL;
                end
                else
                begin
                    r_next  = '0;
                    st_next = BS_DIV;
                end
            end
            BS_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = 52'(rem2 - {1'b0, den_reg});
                    r_next   = {r_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[51:0];
                    r_next   = {r_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(RFRAC - 1))
                    st_next = BS_MUL;
            end
            BS_MUL:
            begin
                st_next = BS_FIN;
            end
            BS_FIN:
            begin
                e_next[sel_reg] = cutv;
                if (!sel_reg)
                begin
                    sel_next = 1'b1;
                    st_next  = BS_SETUP;
                end
                else
                    st_next = BS_EMIT;
            end
            BS_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    st_next = BS_IDLE;
                    if (nrm_reg == 2'd0)
                    begin
                        ot_next = job_reg.v;
                        oc_next = CC_KEEP;
                        ol_next = 1'b1;
                    end
                    else if (nrm_reg == 2'd1)
                    begin
                        oc_next = CC_ONE;
                        if (!ridx_reg)
                        begin
                            ot_next   = {e_reg[1], job_reg.v[k2], job_reg.v[k1]};
                            ol_next   = 1'b0;
                            ridx_next = 1'b1;
                            st_next   = BS_EMIT;
                        end
                        else
                        begin
                            ot_next = {e_reg[0], job_reg.v[k2], e_reg[1]};
                            ol_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ot_next = t;
                        oc_next = CC_TWO;
                        ol_next = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BS_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        k_reg    <= k_next;
        nrm_reg  <= nrm_next;
        sel_reg  <= sel_next;
        ridx_reg <= ridx_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        e_reg    <= e_next;
        ot_reg   <= ot_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
    end

    assign empty    = !ov_reg;
    assign out_tri  = ot_reg;
    assign out_case = oc_reg;
    assign out_last = ol_reg;

endmodule

>>> sv/triangle_plane_clipper.sv
// ---------------------------------------------------------------------------
// triangle_plane_clipper: clips triangles against one configurable plane
// Front computes corner distances, back cuts edges and emits triangles.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//  input     push/full            a_x .. c_z
//  result    empty/pop            out_a_x .. out_c_z, clip_case, last_of_run
//
//  a request goes through the input and product registers into the job queue;
//  input is taken every cycle while the queue has room for all in flight.
//  back end: a fully removed request is dropped, a kept one is emitted as is;
//  one or two removed corners mean two cut edges, each by a ratio division of
//  up to 30 steps in the single shared divider, then the cut products.
//  reset clears control and loads the default plane; the back stalls while its result is not popped.
// ---------------------------------------------------------------------------
module triangle_plane_clipper
    import tpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] out_a_x,
    output logic signed [31:0] out_a_y,
    output logic signed [31:0] out_a_z,
    output logic signed [31:0] out_b_x,
    output logic signed [31:0] out_b_y,
    output logic signed [31:0] out_b_z,
    output logic signed [31:0] out_c_x,
    output logic signed [31:0] out_c_y,
    output logic signed [31:0] out_c_z,
    output logic [1:0]         clip_case,
    output logic               last_of_run
);

    vec_t [2:0]                         in_tri, out_tri;
    job_t                               wr_job, rd_job;
    logic                               wr_en, rd_en, q_empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

    assign cfg_ready = 1'b1;
    assign in_tri    = {{c_x, c_y, c_z}, {b_x, b_y, b_z}, {a_x, a_y, a_z}};

    tpc_front #(.QDEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_tri    (in_tri),
        .q_count   (q_count),
        .wr_en     (wr_en),
        .wr_job    (wr_job)
    );

    tpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_job),
        .rd_en   (rd_en),
        .rd_data (rd_job),
        .empty   (q_empty),
        .count   (q_count)
    );

    tpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (rd_job),
        .q_rd     (rd_en),
        .pop      (pop),
        .empty    (empty),
        .out_tri  (out_tri),
        .out_case (clip_case),
        .out_last (last_of_run)
    );

    assign out_a_x = out_tri[0].x;
    assign out_a_y = out_tri[0].y;
    assign out_a_z = out_tri[0].z;
    assign out_b_x = out_tri[1].x;
    assign out_b_y = out_tri[1].y;
    assign out_b_z = out_tri[1].z;
    assign out_c_x = out_tri[2].x;
    assign out_c_y = out_tri[2].y;
    assign out_c_z = out_tri[2].z;

endmodule

>>> tb/triangle_plane_clipper_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_plane_clipper_checker: result predictor and scoreboard
// Watches the config, input and result channels, predicts the clipped
// triangles of every accepted request and compares them in order.
// ---------------------------------------------------------------------------
module triangle_plane_clipper_checker
    import tpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    input  logic               full,
    input  vec_t               in_a,
    input  vec_t               in_b,
    input  vec_t               in_c,
    input  logic               empty,
    input  logic               pop,
    input  vec_t               res_a,
    input  vec_t               res_b,
    input  vec_t               res_c,
    input  logic [1:0]         clip_case,
    input  logic               last_of_run,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        vec_t       a;
        vec_t       b;
        vec_t       c;
        logic [1:0] cc;
        logic       last;
    } tri_res_t;

    tri_res_t triangles_due[$];

    longint pt_x, pt_y, pt_z;
    longint nrm_x, nrm_y, nrm_z;

    function automatic longint unsigned mag(longint v);
        mag = (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            sat32 = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            sat32 = -64'sd2147483648;
        else
            sat32 = v;
    endfunction

    function automatic longint plane_dist(vec_t p);
        plane_dist = nrm_x * (longint'(p.x) - pt_x) + nrm_y * (longint'(p.y) - pt_y)
                   + nrm_z * (longint'(p.z) - pt_z);
    endfunction

    // new corner on edge p1..p2, weight of p1 is d2 / (d2 - d1)
    function automatic vec_t edge_cut(vec_t p1, vec_t p2, longint d1, longint d2);
        longint unsigned den, num, ratio, rem, dm;
        longint          c1[3], c2[3], r[3], diff;
        vec_t            res;
        den = mag(d2 - d1);
        num = mag(d2);
        ratio = 0;
        c1 = '{p1.x, p1.y, p1.z};
        c2 = '{p2.x, p2.y, p2.z};
        if (den == 0)
            return p2;
        if (num >= den)
            ratio = 64'd1 << RFRAC;
        else
        begin
            rem = num;
            for (int i = 0; i < RFRAC; i++)
            begin
                rem = rem << 1;
                ratio = ratio << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    ratio = ratio | 64'd1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            diff = c1[i] - c2[i];
            dm = (mag(diff) * ratio + (64'd1 << (RFRAC - 1))) >> RFRAC;
            r[i] = sat32((diff < 0) ? c2[i] - longint'(dm) : c2[i] + longint'(dm));
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        return res;
    endfunction

    function automatic void queue_result(tri_res_t r);
        triangles_due = {triangles_due, r};
    endfunction

    function automatic void clip_triangle(vec_t a, vec_t b, vec_t c);
        vec_t     cn[3], t[3], e1, e2;
        longint   d[3];
        bit       rm[3];
        int       n_rm, q, k1, k2;
        cn = '{a, b, c};
        n_rm = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = plane_dist(cn[i]);
            rm[i] = (d[i] >= 0);
            n_rm += rm[i];
        end
        if (n_rm == 0)
            queue_result('{cn[0], cn[1], cn[2], CC_KEEP, 1'b1});
        else if (n_rm == 1)
        begin
            q = rm[0] ? 0 : (rm[1] ? 1 : 2);
            k1 = (q + 1) % 3;
            k2 = (q + 2) % 3;
            e1 = edge_cut(cn[k2], cn[q], d[k2], d[q]);
            e2 = edge_cut(cn[q], cn[k1], d[q], d[k1]);
            queue_result('{cn[k1], cn[k2], e2, CC_ONE, 1'b0});
            queue_result('{e2, cn[k2], e1, CC_ONE, 1'b1});
        end
        else if (n_rm == 2)
        begin
            q = !rm[0] ? 0 : (!rm[1] ? 1 : 2);
            k1 = (q + 1) % 3;
            k2 = (q + 2) % 3;
            t[q] = cn[q];
            t[k1] = edge_cut(cn[q], cn[k1], d[q], d[k1]);
            t[k2] = edge_cut(cn[q], cn[k2], d[q], d[k2]);
            queue_result('{t[0], t[1], t[2], CC_TWO, 1'b1});
        end
    endfunction

    task automatic report(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_triangle(tri_res_t got);
        tri_res_t want;
        string    names[9];
        logic [31:0] g[9], w[9];
        names = '{"out_a_x", "out_a_y", "out_a_z", "out_b_x", "out_b_y", "out_b_z",
                  "out_c_x", "out_c_y", "out_c_z"};
        if (triangles_due.size() == 0)
        begin
            report("triangle popped with none expected");
            return;
        end
        want = triangles_due.pop_front();
        g = '{got.a.x, got.a.y, got.a.z, got.b.x, got.b.y, got.b.z,
              got.c.x, got.c.y, got.c.z};
        w = '{want.a.x, want.a.y, want.a.z, want.b.x, want.b.y, want.b.z,
              want.c.x, want.c.y, want.c.z};
        for (int i = 0; i < 9; i++)
            if (g[i] !== w[i])
                report($sformatf("%s got %h, expected %h", names[i], g[i], w[i]));
        if (got.cc !== want.cc)
            report($sformatf("clip_case got %h, expected %h", got.cc, want.cc));
        if (got.last !== want.last)
            report($sformatf("last_of_run got %h, expected %h", got.last, want.last));
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        pt_x = 0;
        pt_y = 0;
        pt_z = 0;
        nrm_x = 0;
        nrm_y = 0;
        nrm_z = 32767;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                compare_triangle('{res_a, res_b, res_c, clip_case, last_of_run});
            if (push && !full)
                clip_triangle(in_a, in_b, in_c);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PX:  pt_x = longint'(signed'(cfg_data));
                    CFG_PY:  pt_y = longint'(signed'(cfg_data));
                    CFG_PZ:  pt_z = longint'(signed'(cfg_data));
                    CFG_NX:  nrm_x = longint'(signed'(cfg_data[15:0]));
                    CFG_NY:  nrm_y = longint'(signed'(cfg_data[15:0]));
                    CFG_NZ:  nrm_z = longint'(signed'(cfg_data[15:0]));
                    default: ;
                endcase
            end
            pending = triangles_due.size();
        end
    end

endmodule

>>> tb/triangle_plane_clipper_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_plane_clipper_tb: stimulus and verdict for the plane clipper
// Writes several plane settings, sends directed and random triangles under
// varying backpressure and lets the checker score every result.
// ---------------------------------------------------------------------------
module triangle_plane_clipper_tb
    import tpc_pkg::*;
();

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_PX;
    logic [31:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    vec_t        tri_a = '0, tri_b = '0, tri_c = '0;
    logic        empty;
    logic        pop = 1'b0;
    wire vec_t   res_a, res_b, res_c;
    logic [1:0]  clip_case;
    logic        last_of_run;
    int          errors, pending;
    int          tx_idle_pct = 38, rx_idle_pct = 73;
    bit          rx_hold_req = 1'b0;
    int          stall_cycles = 0;
    longint      cur_pt[3];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    triangle_plane_clipper i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .a_x(tri_a.x), .a_y(tri_a.y), .a_z(tri_a.z),
        .b_x(tri_b.x), .b_y(tri_b.y), .b_z(tri_b.z),
        .c_x(tri_c.x), .c_y(tri_c.y), .c_z(tri_c.z),
        .empty(empty), .pop(pop),
        .out_a_x(res_a.x), .out_a_y(res_a.y), .out_a_z(res_a.z),
        .out_b_x(res_b.x), .out_b_y(res_b.y), .out_b_z(res_b.z),
        .out_c_x(res_c.x), .out_c_y(res_c.y), .out_c_z(res_c.z),
        .clip_case(clip_case), .last_of_run(last_of_run)
    );

    triangle_plane_clipper_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .in_a(tri_a), .in_b(tri_b), .in_c(tri_c),
        .empty(empty), .pop(pop),
        .res_a(res_a), .res_b(res_b), .res_c(res_c),
        .clip_case(clip_case), .last_of_run(last_of_run),
        .errors(errors), .pending(pending)
    );

    // receiver: random pop, with a long hold-off on request
    always
    begin
        @(posedge clk);
        if (rx_hold_req)
        begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold_req = 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= CFG_PZ)
            cur_pt[idx[1:0]] = longint'(signed'(value));
    endtask

    task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        write_reg(CFG_PX, px);
        write_reg(CFG_PY, py);
        write_reg(CFG_PZ, pz);
        write_reg(CFG_NX, {16'h0, nx});
        write_reg(CFG_NY, {16'h0, ny});
        write_reg(CFG_NZ, {16'h0, nz});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_triangle(vec_t a, vec_t b, vec_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        tri_a <= a;
        tri_b <= b;
        tri_c <= c;
        do
            @(posedge clk);
        while (full);
    endtask

    // wait for all results, then for result-less requests still in flight
    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int axis);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return 32'(cur_pt[axis] + longint'($urandom_range(32'h0200_0000)) - 64'sh0100_0000);
    endfunction

    function automatic vec_t rand_corner();
        vec_t v;
        v.x = rand_coord(0);
        v.y = rand_coord(1);
        v.z = rand_coord(2);
        return v;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_triangle(rand_corner(), rand_corner(), rand_corner());
    endtask

    function automatic vec_t pz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    initial
    begin
        cur_pt = '{0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset plane: z = 0 with normal +z, negative z is kept
        send_triangle(pz(32'h0001_0000, 0, 32'hffff_0000), pz(0, 32'h0001_0000, 32'hfffe_0000),
                      pz(32'hffff_0000, 0, 32'hfffc_0000));
        send_triangle(pz(0, 0, 32'h0001_0000), pz(32'h0001_0000, 0, 32'h0002_0000),
                      pz(0, 32'h0001_0000, 32'h0003_0000));
        for (int q = 0; q < 3; q++)
        begin
            send_triangle(pz(0, 0, (q == 0) ? 32'h0002_0000 : 32'hffff_0000),
                          pz(32'h0003_0000, 0, (q == 1) ? 32'h0001_8000 : 32'hfffd_0000),
                          pz(0, 32'h0005_0000, (q == 2) ? 32'h0000_4000 : 32'hfffe_8000));
            send_triangle(pz(32'h0001_0000, 32'h0002_0000, (q == 0) ? 32'hfffe_0000 : 32'h0001_0000),
                          pz(32'hfff0_0000, 0, (q == 1) ? 32'hffff_c000 : 32'h0003_0000),
                          pz(0, 32'hffff_0000, (q == 2) ? 32'hffff_0001 : 32'h0000_8000));
        end
        // corner exactly on the plane counts as removed
        send_triangle(pz(0, 0, 0), pz(32'h0001_0000, 0, 32'hffff_0000),
                      pz(0, 32'h0001_0000, 32'hfffe_0000));
        send_triangle(pz(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff),
                      pz(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000),
                      pz(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff));
        send_triangle(pz(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000),
                      pz(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001),
                      pz(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000));
        send_random(80);
        drain();

        set_plane($urandom_range(32'h00ff_ffff), 32'h7fff_ffff, 32'h8000_0000,
                  16'h7fff, 16'h0000, 16'h0000);
        // receiver holds off while requests keep coming
        rx_hold_req = 1'b1;
        send_random(75);
        drain();

        tx_idle_pct = 73;
        rx_idle_pct = 38;
        set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 16'h8000, 16'h0000, 16'h0000);
        send_random(90);
        drain();
        set_plane($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(75);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // zero normal removes every corner
        set_plane($urandom, $urandom, $urandom, 16'h0000, 16'h0000, 16'h0000);
        send_random(12);
        drain();
        set_plane($urandom_range(32'h000f_ffff), $urandom_range(32'h000f_ffff), 0,
                  16'd12000, 16'hb1e0, 16'h3e80);
        send_random(105);
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
sv/tpc_pkg.sv
sv/tpc_front.sv
sv/tpc_queue.sv
sv/tpc_back.sv
sv/triangle_plane_clipper.sv
tb/triangle_plane_clipper_checker.sv
tb/triangle_plane_clipper_tb.sv
